// File: hdl/byte_ring_buffer_with_spans_defines.svh
// assertion macros for the byte ring buffer top level
// used by byte_ring_buffer_with_spans.sv, expects clk and rst_n in scope
`ifndef BYTE_RING_BUFFER_WITH_SPANS_DEFINES_SVH
`define BYTE_RING_BUFFER_WITH_SPANS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BRB_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("brb: same-cycle check failed");

// next-cycle implication, disabled during reset
`define BRB_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("brb: next-cycle check failed");

`endif

// File: hdl/brb_pkg.sv
// shared types and constants for the byte ring buffer
// no dependencies
package brb_pkg;

  localparam int DEPTH = 1024;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 11;
  localparam int OFF_W = 10;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    CMD_PUT     = 2'd0,
    CMD_GET     = 2'd1,
    CMD_COMMIT  = 2'd2,
    CMD_CONSUME = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_WRAP,
    ST_SPAN,
    ST_LOAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic wrap;
    logic span;
    logic load;
  } ctrl_t;

endpackage

// File: hdl/brb_ram.sv
// generic single-port ram with registered read
// no dependencies
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/brb_ctrl.sv
// sequencer for the byte ring buffer: one word at a time through five steps
// depends on brb_pkg
module brb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  output brb_pkg::ctrl_t ctrl
);

  brb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brb_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = brb_pkg::ST_CALC;
        end
      end
      brb_pkg::ST_CALC: state_nxt = brb_pkg::ST_WRAP;
      brb_pkg::ST_WRAP: state_nxt = brb_pkg::ST_SPAN;
      brb_pkg::ST_SPAN: state_nxt = brb_pkg::ST_LOAD;
      brb_pkg::ST_LOAD: state_nxt = brb_pkg::ST_OUT;
      brb_pkg::ST_OUT:  state_nxt = brb_pkg::ST_IDLE;
      default:          state_nxt = brb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      brb_pkg::ST_IDLE: begin
        busy         = 1'b0;
        ctrl.capture = start;
      end
      brb_pkg::ST_CALC: ctrl.calc = 1'b1;
      brb_pkg::ST_WRAP: ctrl.wrap = 1'b1;
      brb_pkg::ST_SPAN: ctrl.span = 1'b1;
      brb_pkg::ST_LOAD: ctrl.load = 1'b1;
      brb_pkg::ST_OUT:  out_valid = 1'b1;
      default:          busy = 1'b1;
    endcase
  end

endmodule

// File: hdl/brb_datapath.sv
// indices, fill count, capacity register, byte store and span logic
// depends on brb_pkg and brb_ram
module brb_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  brb_pkg::ctrl_t               ctrl,
  input  logic                         cfg_write,
  input  logic [brb_pkg::CNT_W-1:0]    cfg_capacity,
  input  logic [1:0]                   in_command,
  input  logic [brb_pkg::OFF_W-1:0]    in_offset,
  input  logic [brb_pkg::BYTE_W-1:0]   in_data_in,
  input  logic [brb_pkg::CNT_W-1:0]    in_amount,
  output logic [brb_pkg::BYTE_W-1:0]   out_data_out,
  output logic                         out_ok,
  output logic [brb_pkg::CNT_W-1:0]    out_fill_count,
  output logic [brb_pkg::CNT_W-1:0]    out_read_span,
  output logic [brb_pkg::CNT_W-1:0]    out_write_span
);

  localparam int CW = brb_pkg::CNT_W;
  localparam int IW = brb_pkg::IDX_W;

  // architectural state
  logic [CW-1:0] cap_r, cap_nxt;
  logic [IW-1:0] wi_r, wi_nxt;
  logic [IW-1:0] ri_r, ri_nxt;
  logic [CW-1:0] held_r, held_nxt;

  // captured word and intermediates
  brb_pkg::cmd_t              cmd_r;
  logic [brb_pkg::OFF_W-1:0]  off_r;
  logic [brb_pkg::BYTE_W-1:0] din_r;
  logic [CW-1:0]              amt_r;
  logic [CW-1:0]              room_r;
  logic                       ok_r, ok_nxt;
  logic [CW-1:0]              delta_r, delta_nxt;
  logic [CW:0]                sum_r, sum_nxt;
  logic [CW-1:0]              rs_raw_r, ws_raw_r, room2_r;
  logic [brb_pkg::BYTE_W-1:0] dout_r;

  // output registers
  logic [brb_pkg::BYTE_W-1:0] odata_r;
  logic                       ook_r;
  logic [CW-1:0]              ofill_r, ors_r, ows_r;

  logic [CW-1:0]              cap_clamped;
  logic [CW:0]                base_ext;
  logic [CW:0]                pos_full;
  logic [IW-1:0]              pos;
  logic                       ram_we, ram_re;
  logic [brb_pkg::BYTE_W-1:0] ram_rdata;

  // 0 acts as 1, anything above the store depth acts as the depth
  always_comb begin
    priority if (cfg_capacity == '0) begin
      cap_clamped = CW'(1);
    end else if (cfg_capacity > CW'(brb_pkg::DEPTH)) begin
      cap_clamped = CW'(brb_pkg::DEPTH);
    end else begin
      cap_clamped = cfg_capacity;
    end
  end

  // region check, clamp and base + delta
  always_comb begin
    ok_nxt    = 1'b0;
    delta_nxt = '0;
    base_ext  = '0;
    unique case (cmd_r)
      brb_pkg::CMD_PUT: begin
        ok_nxt    = CW'(off_r) < room_r;
        delta_nxt = CW'(off_r);
        base_ext  = (CW+1)'(wi_r);
      end
      brb_pkg::CMD_GET: begin
        ok_nxt    = CW'(off_r) < held_r;
        delta_nxt = CW'(off_r);
        base_ext  = (CW+1)'(ri_r);
      end
      brb_pkg::CMD_COMMIT: begin
        delta_nxt = (amt_r > room_r) ? room_r : amt_r;
        base_ext  = (CW+1)'(wi_r);
      end
      brb_pkg::CMD_CONSUME: begin
        delta_nxt = (amt_r > held_r) ? held_r : amt_r;
        base_ext  = (CW+1)'(ri_r);
      end
      default: ok_nxt = 1'b0;
    endcase
    sum_nxt = base_ext + (CW+1)'(delta_nxt);
  end

  // base < cap and delta <= cap, so one conditional subtract wraps
  assign pos_full = (sum_r >= (CW+1)'(cap_r)) ? (sum_r - (CW+1)'(cap_r)) : sum_r;
  assign pos      = pos_full[IW-1:0];

  assign ram_we = ctrl.wrap && (cmd_r == brb_pkg::CMD_PUT) && ok_r;
  assign ram_re = ctrl.wrap && (cmd_r == brb_pkg::CMD_GET) && ok_r;

  brb_ram #(
    .WIDTH (brb_pkg::BYTE_W),
    .DEPTH (brb_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (pos),
    .wdata (din_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    cap_nxt  = cap_r;
    wi_nxt   = wi_r;
    ri_nxt   = ri_r;
    held_nxt = held_r;
    if (cfg_write) begin
      cap_nxt  = cap_clamped;
      wi_nxt   = '0;
      ri_nxt   = '0;
      held_nxt = '0;
    end else if (ctrl.wrap && (cmd_r == brb_pkg::CMD_COMMIT)) begin
      wi_nxt   = pos;
      held_nxt = held_r + delta_r;
    end else if (ctrl.wrap && (cmd_r == brb_pkg::CMD_CONSUME)) begin
      ri_nxt   = pos;
      held_nxt = held_r - delta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CW'(brb_pkg::DEPTH);
      wi_r   <= '0;
      ri_r   <= '0;
      held_r <= '0;
    end else begin
      cap_r  <= cap_nxt;
      wi_r   <= wi_nxt;
      ri_r   <= ri_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r  <= brb_pkg::cmd_t'(in_command);
      off_r  <= in_offset;
      din_r  <= in_data_in;
      amt_r  <= in_amount;
      room_r <= cap_r - held_r;
    end
    if (ctrl.calc) begin
      ok_r    <= ok_nxt;
      delta_r <= delta_nxt;
      sum_r   <= sum_nxt;
    end
    // indices already updated here; store read data arrives this cycle
    if (ctrl.span) begin
      rs_raw_r <= (ri_r < wi_r) ? CW'(wi_r - ri_r) : (cap_r - CW'(ri_r));
      ws_raw_r <= (wi_r < ri_r) ? CW'(ri_r - wi_r) : (cap_r - CW'(wi_r));
      room2_r  <= cap_r - held_r;
      dout_r   <= ((cmd_r == brb_pkg::CMD_GET) && ok_r) ? ram_rdata : '0;
    end
    // an empty buffer or a full one falls out of the min as zero
    if (ctrl.load) begin
      odata_r <= dout_r;
      ook_r   <= ok_r;
      ofill_r <= held_r;
      ors_r   <= (rs_raw_r > held_r) ? held_r : rs_raw_r;
      ows_r   <= (ws_raw_r > room2_r) ? room2_r : ws_raw_r;
    end
  end

  assign out_data_out   = odata_r;
  assign out_ok         = ook_r;
  assign out_fill_count = ofill_r;
  assign out_read_span  = ors_r;
  assign out_write_span = ows_r;

endmodule

// File: hdl/byte_ring_buffer_with_spans.sv
// Byte ring buffer with contiguous span reporting.
// Commands: put (byte at head + offset), get (byte at tail + offset),
// commit (advance head, clamped to free space), consume (advance tail,
// clamped to fill count). A word is taken on start while busy is low.
// Each word gives exactly one result, shown on the out_ ports for one
// cycle with out_valid high; the receiver cannot stall it.
// Busy stays high from the accepting edge until the result cycle ends,
// so a new word is taken only after the last one is through. Each word runs
// through the five-step sequencer around the single-port byte store
// (bound check, index wrap with store access, span compare, span clamp).
// Configuration: cfg_capacity is written when cfg_valid and cfg_ready are
// high; cfg_ready is low while a word is in flight or being started, so a
// word on start wins over a capacity write in the same cycle. A write
// empties the buffer but keeps the stored bytes; 0 acts as 1, above 1024
// acts as 1024.
// Reset: capacity returns to 1024, head, tail and fill count to zero; the
// store contents are undefined until written. No clearing pass is needed.
// Depends on brb_pkg, brb_ctrl, brb_datapath, brb_ram and the defines header.
`include "byte_ring_buffer_with_spans_defines.svh"

module byte_ring_buffer_with_spans (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_command,
  input  logic [brb_pkg::OFF_W-1:0]   in_offset,
  input  logic [brb_pkg::BYTE_W-1:0]  in_data_in,
  input  logic [brb_pkg::CNT_W-1:0]   in_amount,
  output logic                        out_valid,
  output logic [brb_pkg::BYTE_W-1:0]  out_data_out,
  output logic                        out_ok,
  output logic [brb_pkg::CNT_W-1:0]   out_fill_count,
  output logic [brb_pkg::CNT_W-1:0]   out_read_span,
  output logic [brb_pkg::CNT_W-1:0]   out_write_span,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [brb_pkg::CNT_W-1:0]   cfg_capacity
);

  brb_pkg::ctrl_t ctrl;

  // a word being started counts as in flight
  assign cfg_ready = !busy && !start;

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  brb_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_capacity   (cfg_capacity),
    .in_command     (in_command),
    .in_offset      (in_offset),
    .in_data_in     (in_data_in),
    .in_amount      (in_amount),
    .out_data_out   (out_data_out),
    .out_ok         (out_ok),
    .out_fill_count (out_fill_count),
    .out_read_span  (out_read_span),
    .out_write_span (out_write_span)
  );

  `BRB_ASSERT_NXT(a_accept_goes_busy, start && !busy, busy)
  `BRB_ASSERT_NXT(a_single_strobe, out_valid, !out_valid)
  `BRB_ASSERT_IMP(a_read_span_bound, out_valid, out_read_span <= out_fill_count)
  `BRB_ASSERT_IMP(a_no_data_on_miss, out_valid && !out_ok, out_data_out == '0)

endmodule
